FILE: rtl/gtr_pkg.sv
// Shared constants and types for the graph traversal block.
// No dependencies; used by the scan lanes, the merge stage, the top level and the checker.
package gtr_pkg;

  // Graph and store sizes
  localparam int MaxVertices = 32;
  localparam int StackDepth  = 64;

  // Port widths fixed by the interface
  localparam int VertexW = 6;
  localparam int CountW  = 6;
  localparam int RowW    = 32;

  // Internal widths
  localparam int VIdxW  = $clog2(MaxVertices);
  localparam int QPtrW  = $clog2(MaxVertices + 1);
  localparam int SIdxW  = $clog2(StackDepth);
  localparam int SLvlW  = $clog2(StackDepth + 1);

  // Neighbor scan split into lanes
  localparam int NumLanes  = 4;
  localparam int LaneWidth = MaxVertices / NumLanes;
  localparam int LaneIdxW  = $clog2(LaneWidth);
  localparam int LaneSelW  = $clog2(NumLanes);

  // Item modes
  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeBfs  = 2'd1;
  localparam logic [1:0] ModeDfs  = 2'd2;

  // What one lane found in its slice of the neighbor mask
  typedef struct packed {
    logic                hit;
    logic [LaneIdxW-1:0] pos;
  } lane_hit_t;

  // Merged scan result: vertex index (vertex number minus one)
  typedef struct packed {
    logic             hit;
    logic [VIdxW-1:0] idx;
  } scan_t;

endpackage

FILE: rtl/gtr_scan_lane.sv
// One lane of the neighbor scan: finds the lowest or highest set bit in its slice.
// Depends on gtr_pkg.
module gtr_scan_lane (
  input  logic [gtr_pkg::LaneWidth-1:0] seg_i,
  input  logic                          from_top_i,
  output gtr_pkg::lane_hit_t            hit_o
);
  import gtr_pkg::*;

  always_comb begin
    hit_o = '0;
    if (from_top_i) begin
      // ascending walk, last hit wins: highest bit
      for (int k = 0; k < LaneWidth; k++) begin
        if (seg_i[k]) begin
          hit_o.hit = 1'b1;
          hit_o.pos = LaneIdxW'(k);
        end
      end
    end else begin
      // descending walk, last hit wins: lowest bit
      for (int k = LaneWidth - 1; k >= 0; k--) begin
        if (seg_i[k]) begin
          hit_o.hit = 1'b1;
          hit_o.pos = LaneIdxW'(k);
        end
      end
    end
  end

endmodule

FILE: rtl/gtr_scan_merge.sv
// Merge stage of the neighbor scan: picks the winning lane and forms the vertex index.
// Depends on gtr_pkg.
module gtr_scan_merge (
  input  gtr_pkg::lane_hit_t [gtr_pkg::NumLanes-1:0] lanes_i,
  input  logic                                       from_top_i,
  output gtr_pkg::scan_t                             result_o
);
  import gtr_pkg::*;

  always_comb begin
    result_o = '0;
    if (from_top_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        if (lanes_i[l].hit) begin
          result_o.hit = 1'b1;
          result_o.idx = {LaneSelW'(l), lanes_i[l].pos};
        end
      end
    end else begin
      for (int l = NumLanes - 1; l >= 0; l--) begin
        if (lanes_i[l].hit) begin
          result_o.hit = 1'b1;
          result_o.idx = {LaneSelW'(l), lanes_i[l].pos};
        end
      end
    end
  end

endmodule

FILE: rtl/graph_traversal_bfs_dfs_top.sv
// Graph traversal block (breadth-first and depth-first) over an adjacency matrix.
// Depends on gtr_pkg, gtr_scan_lane and gtr_scan_merge.
//
// A transaction is taken at a rising edge with start high and busy low. A load
// (mode 0) writes one adjacency row in that cycle and leaves busy low. A traversal
// (mode 1 breadth-first, mode 2 depth-first) with a valid start vertex raises busy
// and emits the visited vertices one per strobe on vertex_valid_o, the final one
// with last_o set; the receiver cannot stall, so take every strobe. Breadth-first
// pops a vertex from the queue, reads its row, marks the new active neighbors and
// then scans them out into the queue. Depth-first pops the stack, reads the row,
// marks the popped vertex if it is new, then scans the new neighbors onto the
// stack; pops of already visited vertices still read and scan their row. The walk
// is paced by the single read port of the row memory and of the queue or stack,
// and by the neighbor scan handing out one neighbor per cycle. Results trail
// their discovery by one vertex, since a vertex is only known to be final once
// the walk has ended. Configuration (vertex_count) is written through its own
// valid/ready channel, always ready.
module graph_traversal_bfs_dfs_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode_i,
  input  logic [gtr_pkg::VertexW-1:0] row_vertex_i,
  input  logic [gtr_pkg::RowW-1:0]    row_edges_i,
  input  logic [gtr_pkg::VertexW-1:0] start_vertex_i,
  // result channel
  output logic                        vertex_valid_o,
  output logic [gtr_pkg::VertexW-1:0] vertex_o,
  output logic                        last_o,
  // configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gtr_pkg::CountW-1:0]  cfg_data_i
);
  import gtr_pkg::*;

  typedef enum logic [9:0] {
    StIdle  = 10'b00_0000_0001,
    StBPop  = 10'b00_0000_0010,
    StBRow  = 10'b00_0000_0100,
    StBMask = 10'b00_0000_1000,
    StBScan = 10'b00_0001_0000,
    StDPop  = 10'b00_0010_0000,
    StDRow  = 10'b00_0100_0000,
    StDMask = 10'b00_1000_0000,
    StDScan = 10'b01_0000_0000,
    StFin   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0]      vc_q;
  logic [MaxVertices-1:0] visited_q, visited_d;
  logic [MaxVertices-1:0] mask_q, mask_d;
  logic [QPtrW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [SLvlW-1:0]       level_q, level_d;
  logic [VIdxW-1:0]       pend_q, pend_d;
  logic                   pend_vld_q, pend_vld_d;
  logic                   out_vld_q, out_vld_d;
  logic [VertexW-1:0]     out_vertex_q, out_vertex_d;
  logic                   out_last_q, out_last_d;

  // Memories: adjacency rows, breadth-first queue, depth-first stack
  logic [MaxVertices-1:0] adj_mem [MaxVertices];
  logic [VIdxW-1:0]       q_mem   [MaxVertices];
  logic [VIdxW-1:0]       s_mem   [StackDepth];

  logic                   adj_we;
  logic [VIdxW-1:0]       adj_waddr, adj_raddr;
  logic [MaxVertices-1:0] adj_rd_q;
  logic                   q_we;
  logic [VIdxW-1:0]       q_waddr, q_wdata, q_raddr, q_rd_q;
  logic                   s_we;
  logic [SIdxW-1:0]       s_waddr, s_raddr;
  logic [VIdxW-1:0]       s_wdata, s_rd_q;

  logic [CountW-1:0]      n_act;
  logic [MaxVertices-1:0] act_mask;
  logic                   accept, start_ok, row_ok;
  logic [VIdxW-1:0]       s_idx;
  logic                   visit;
  logic [VIdxW-1:0]       visit_x;
  logic [MaxVertices-1:0] new_nb;

  // Scan lanes and merge
  lane_hit_t [NumLanes-1:0] lane_hits;
  scan_t                    scan;
  logic                     from_top;

  assign from_top = (state_q == StDScan);

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    gtr_scan_lane u_lane (
      .seg_i      (mask_q[l*LaneWidth +: LaneWidth]),
      .from_top_i (from_top),
      .hit_o      (lane_hits[l])
    );
  end

  gtr_scan_merge u_merge (
    .lanes_i    (lane_hits),
    .from_top_i (from_top),
    .result_o   (scan)
  );

  // Effective vertex count and its mask
  assign n_act = (vc_q > CountW'(MaxVertices)) ? CountW'(MaxVertices) : vc_q;

  always_comb begin
    for (int i = 0; i < MaxVertices; i++) begin
      act_mask[i] = (CountW'(i) < n_act);
    end
  end

  assign busy        = (state_q != StIdle);
  assign accept      = start && !busy;
  assign start_ok    = (start_vertex_i != '0) && (start_vertex_i <= n_act);
  assign row_ok      = (row_vertex_i != '0) && (row_vertex_i <= VertexW'(MaxVertices));
  assign s_idx       = VIdxW'(start_vertex_i - VertexW'(1));
  assign cfg_ready_o = 1'b1;

  // Fixed read addresses: queue at head, stack at top, row at the current vertex
  assign q_raddr   = head_q[VIdxW-1:0];
  assign s_raddr   = SIdxW'(level_q - SLvlW'(1));
  assign adj_raddr = (state_q == StBRow) ? q_rd_q : s_rd_q;
  assign adj_waddr = VIdxW'(row_vertex_i - VertexW'(1));
  assign new_nb    = adj_rd_q & ~visited_q & act_mask;

  always_comb begin
    state_d   = state_q;
    visited_d = visited_q;
    mask_d    = mask_q;
    head_d    = head_q;
    tail_d    = tail_q;
    level_d   = level_q;
    adj_we    = 1'b0;
    q_we      = 1'b0;
    q_waddr   = tail_q[VIdxW-1:0];
    q_wdata   = scan.idx;
    s_we      = 1'b0;
    s_waddr   = level_q[SIdxW-1:0];
    s_wdata   = scan.idx;
    visit     = 1'b0;
    visit_x   = q_rd_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (mode_i == ModeLoad) begin
            adj_we = row_ok;
          end else if (mode_i == ModeBfs && start_ok) begin
            // seed queue with the start vertex and mark it
            visited_d = MaxVertices'(1) << s_idx;
            q_we      = 1'b1;
            q_waddr   = '0;
            q_wdata   = s_idx;
            head_d    = '0;
            tail_d    = QPtrW'(1);
            state_d   = StBPop;
          end else if (mode_i == ModeDfs && start_ok) begin
            visited_d = '0;
            s_we      = 1'b1;
            s_waddr   = '0;
            s_wdata   = s_idx;
            level_d   = SLvlW'(1);
            state_d   = StDPop;
          end
        end
      end
      StBPop: begin
        if (head_q == tail_q) begin
          state_d = StFin;
        end else begin
          head_d  = head_q + QPtrW'(1);
          state_d = StBRow;
        end
      end
      StBRow: begin
        visit   = 1'b1;
        visit_x = q_rd_q;
        state_d = StBMask;
      end
      StBMask: begin
        // every new neighbor gets marked here, before it is queued
        mask_d    = new_nb;
        visited_d = visited_q | new_nb;
        state_d   = StBScan;
      end
      StBScan: begin
        if (scan.hit) begin
          if (tail_q < QPtrW'(MaxVertices)) begin
            q_we   = 1'b1;
            tail_d = tail_q + QPtrW'(1);
          end
          mask_d = mask_q & ~(MaxVertices'(1) << scan.idx);
        end else begin
          state_d = StBPop;
        end
      end
      StDPop: begin
        if (level_q == '0) begin
          state_d = StFin;
        end else begin
          level_d = level_q - SLvlW'(1);
          state_d = StDRow;
        end
      end
      StDRow: begin
        visit_x = s_rd_q;
        if (!visited_q[s_rd_q]) begin
          visit     = 1'b1;
          visited_d = visited_q | (MaxVertices'(1) << s_rd_q);
        end
        state_d = StDMask;
      end
      StDMask: begin
        mask_d  = new_nb;
        state_d = StDScan;
      end
      StDScan: begin
        // push highest first; once the stack is full the rest are dropped
        if (scan.hit && level_q < SLvlW'(StackDepth)) begin
          s_we    = 1'b1;
          level_d = level_q + SLvlW'(1);
          mask_d  = mask_q & ~(MaxVertices'(1) << scan.idx);
        end else begin
          state_d = StDPop;
        end
      end
      StFin: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Result path: hold one visited vertex back until the next one shows up or the
  // walk ends, so the final vertex can carry last.
  always_comb begin
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    out_vld_d    = 1'b0;
    out_vertex_d = out_vertex_q;
    out_last_d   = out_last_q;
    if (visit) begin
      if (pend_vld_q) begin
        out_vld_d    = 1'b1;
        out_vertex_d = VertexW'(pend_q) + VertexW'(1);
        out_last_d   = 1'b0;
      end
      pend_d     = visit_x;
      pend_vld_d = 1'b1;
    end else if (state_q == StFin) begin
      out_vld_d    = pend_vld_q;
      out_vertex_d = VertexW'(pend_q) + VertexW'(1);
      out_last_d   = 1'b1;
      pend_vld_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      vc_q       <= CountW'(32);
      visited_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      level_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      visited_q  <= visited_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      level_q    <= level_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vc_q <= cfg_data_i;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    mask_q       <= mask_d;
    pend_q       <= pend_d;
    out_vertex_q <= out_vertex_d;
    out_last_q   <= out_last_d;
  end

  // Adjacency row memory
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= MaxVertices'(row_edges_i);
    end
    adj_rd_q <= adj_mem[adj_raddr];
  end

  // Breadth-first queue
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd_q <= q_mem[q_raddr];
  end

  // Depth-first stack
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= s_wdata;
    end
    s_rd_q <= s_mem[s_raddr];
  end

  assign vertex_valid_o = out_vld_q;
  assign vertex_o       = out_vertex_q;
  assign last_o         = out_last_q;

endmodule

FILE: rtl/gtr_checker.sv
// Port-level checker for the graph traversal block, with its bind to the top level.
// Depends on gtr_pkg and graph_traversal_bfs_dfs_top.
module gtr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        vertex_valid_o,
  input logic [gtr_pkg::VertexW-1:0] vertex_o,
  input logic                        last_o
);
  import gtr_pkg::*;

  // every emitted vertex is a real vertex number
  a_vertex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_valid_o |-> (vertex_o != '0) && (vertex_o <= VertexW'(MaxVertices)))
    else $error("vertex out of range");

  // the final vertex of a walk shows only once the block is free again
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_valid_o && last_o |-> !busy)
    else $error("last vertex while busy");

  // non-final vertices only appear while the walk is running
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_valid_o && !last_o |-> busy)
    else $error("non-final vertex outside a walk");

  // a walk always closes with a flagged vertex
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> vertex_valid_o && last_o)
    else $error("walk ended without last vertex");

  // a transaction taken in idle produces nothing in the following cycle
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !vertex_valid_o)
    else $error("result right after accepted transaction");

endmodule

bind graph_traversal_bfs_dfs_top gtr_checker u_gtr_checker (.*);

FILE: tb/sv/graph_traversal_bfs_dfs_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for graph_traversal_bfs_dfs_top: loads adjacency rows, runs
// breadth-first and depth-first walks and checks every emitted vertex. Depends on gtr_pkg.
module graph_traversal_bfs_dfs_top_tb;
  import gtr_pkg::*;

  localparam int ClkHalf = 5;
  // The slowest walk is a dense depth-first one with about a thousand stack pushes and pops.
  // Allow roughly 200 such walks plus idle gaps, then double it.
  localparam int CycleLimit = 4_000_000;
  // Mode 3 has no name in the package; the block ignores it.
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [VertexW-1:0] vertex;
    logic               last;
  } visit_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic [1:0]          mode_i         = ModeLoad;
  logic [VertexW-1:0]  row_vertex_i   = '0;
  logic [RowW-1:0]     row_edges_i    = '0;
  logic [VertexW-1:0]  start_vertex_i = '0;
  logic                vertex_valid_o;
  logic [VertexW-1:0]  vertex_o;
  logic                last_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CountW-1:0]   cfg_data_i     = '0;

  // Local copy of the block's state: the adjacency matrix and the vertex count.
  logic [RowW-1:0]     adj_rows [MaxVertices];
  logic [CountW-1:0]   vertex_limit = CountW'(32);
  // Visits still owed by the block, oldest first.
  visit_t              visit_q [$];
  int                  error_count = 0;
  int                  cycle_count = 0;
  // Chance, in percent, that the sender goes idle after a transaction; it stays idle with the same chance.
  int                  sender_idle_pct = 0;

  graph_traversal_bfs_dfs_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .row_vertex_i   (row_vertex_i),
    .row_edges_i    (row_edges_i),
    .start_vertex_i (start_vertex_i),
    .vertex_valid_o (vertex_valid_o),
    .vertex_o       (vertex_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  // Counts above 32 saturate; only neighbors 1..count are scanned.
  function automatic int active_vertices();
    int n;
    n = int'(vertex_limit);
    if (n > 32) n = 32;
    if (n > MaxVertices) n = MaxVertices;
    return n;
  endfunction

  // Apply one accepted transaction to the local state and queue the visits it owes.
  function automatic void predict_visits(logic [1:0] item_mode, logic [VertexW-1:0] row_idx,
                                         logic [RowW-1:0] row_bits, logic [VertexW-1:0] root);
    int                     n, x, head, tail, level;
    logic [MaxVertices-1:0] marks;
    int                     ring [MaxVertices];
    int                     stack [StackDepth];
    int                     order [$];
    visit_t                 v;
    if (item_mode == ModeLoad) begin
      // Row 0 and rows past the matrix are dropped.
      if (row_idx >= 1 && row_idx <= MaxVertices) adj_rows[row_idx - 1] = row_bits;
      return;
    end
    if (item_mode != ModeBfs && item_mode != ModeDfs) return;
    n = active_vertices();
    if (root < 1 || root > n) return;
    marks = '0;
    if (item_mode == ModeBfs) begin
      // Mark on enqueue, lowest neighbor first; pointers restart for every walk.
      head = 0;
      tail = 1;
      ring[0] = int'(root);
      marks[root - 1] = 1'b1;
      while (head < tail) begin
        x = ring[head];
        head++;
        order.push_back(x);
        for (int i = 1; i <= n; i++) begin
          if (adj_rows[x - 1][i - 1] && !marks[i - 1]) begin
            if (tail < MaxVertices) begin
              ring[tail] = i;
              tail++;
            end
            marks[i - 1] = 1'b1;
          end
        end
      end
    end else begin
      // Mark on pop; push unmarked neighbors highest first even after a stale pop,
      // and drop pushes onto a full stack.
      level = 1;
      stack[0] = int'(root);
      while (level > 0) begin
        level--;
        x = stack[level];
        if (!marks[x - 1]) begin
          if (order.size() < MaxVertices) order.push_back(x);
          marks[x - 1] = 1'b1;
        end
        for (int i = n; i >= 1; i--) begin
          if (adj_rows[x - 1][i - 1] && !marks[i - 1] && level < StackDepth) begin
            stack[level] = i;
            level++;
          end
        end
      end
    end
    foreach (order[k]) begin
      v.vertex = VertexW'(order[k]);
      v.last   = (k == order.size() - 1);
      visit_q.push_back(v);
    end
  endfunction

  function automatic logic [RowW-1:0] random_row();
    case ($urandom_range(3))
      0: return $urandom & $urandom & $urandom;     // sparse
      1: return $urandom;
      2: return '1;                                 // complete
      default: return ~($urandom & $urandom & $urandom);  // dense
    endcase
  endfunction

  // Drive one item, hold it until the block takes it, then idle per the current phase.
  // Leave start high when no idle follows so back-to-back items need no gap.
  task automatic send_item(logic [1:0] item_mode, logic [VertexW-1:0] row_idx,
                           logic [RowW-1:0] row_bits, logic [VertexW-1:0] root);
    mode_i         <= item_mode;
    row_vertex_i   <= row_idx;
    row_edges_i    <= row_bits;
    start_vertex_i <= root;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_visits(item_mode, row_idx, row_bits, root);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Drop start, wait for every owed visit, then give a walk with no visits time to finish.
  task automatic drain_visits();
    start <= 1'b0;
    while (visit_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Write vertex_count only with the block idle.
  task automatic write_vertex_count(logic [CountW-1:0] value);
    drain_visits();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    vertex_limit = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Fill every row so no walk ever reads an unwritten one; try the two ignored row indexes.
  task automatic test_matrix_load();
    sender_idle_pct = 0;
    for (int v = 1; v <= MaxVertices; v++)
      send_item(ModeLoad, VertexW'(v), random_row(), VertexW'($urandom));
    send_item(ModeLoad, VertexW'(0), '1, VertexW'($urandom));
    send_item(ModeLoad, VertexW'(63), '1, VertexW'($urandom));
  endtask

  // Complete graph on 16 vertices: the depth-first walk overflows the stack.
  task automatic test_complete_graph();
    write_vertex_count(CountW'(16));
    for (int v = 1; v <= 16; v++) send_item(ModeLoad, VertexW'(v), '1, VertexW'($urandom));
    send_item(ModeBfs, VertexW'($urandom), $urandom, VertexW'(1));
    send_item(ModeDfs, VertexW'($urandom), $urandom, VertexW'(16));
    send_item(ModeDfs, VertexW'($urandom), $urandom, VertexW'(1));
    send_item(ModeBfs, VertexW'($urandom), $urandom, VertexW'(16));
  endtask

  // A vertex with no edges yields a single visit flagged last.
  task automatic test_isolated_vertex();
    send_item(ModeLoad, VertexW'(5), '0, VertexW'($urandom));
    send_item(ModeBfs, VertexW'($urandom), $urandom, VertexW'(5));
    send_item(ModeDfs, VertexW'($urandom), $urandom, VertexW'(5));
  endtask

  // Unused mode and out-of-range start vertices yield nothing; a valid depth-first walk follows.
  task automatic test_ignored_items();
    send_item(ModeUnused, VertexW'($urandom), $urandom, VertexW'($urandom));
    send_item(ModeBfs, VertexW'($urandom), $urandom, VertexW'(0));
    send_item(ModeDfs, VertexW'($urandom), $urandom, VertexW'(17));
    send_item(ModeBfs, VertexW'($urandom), $urandom, VertexW'(63));
    send_item(ModeDfs, VertexW'($urandom), $urandom, VertexW'(2));
  endtask

  // Vertex count extremes: one vertex, none, and a value that saturates to 32.
  task automatic test_vertex_count();
    write_vertex_count(CountW'(1));
    send_item(ModeBfs, VertexW'($urandom), $urandom, VertexW'(1));
    send_item(ModeDfs, VertexW'($urandom), $urandom, VertexW'(1));
    send_item(ModeBfs, VertexW'($urandom), $urandom, VertexW'(2));
    write_vertex_count(CountW'(0));
    send_item(ModeBfs, VertexW'($urandom), $urandom, VertexW'(1));
    write_vertex_count(CountW'(63));
    send_item(ModeDfs, VertexW'($urandom), $urandom, VertexW'(32));
    send_item(ModeBfs, VertexW'($urandom), $urandom, VertexW'(32));
  endtask

  // Mostly loads and well-formed walks with random content; a little noise.
  // Pause once mid-phase until every visit is in.
  task automatic test_random_traffic(int idle_pct, logic [CountW-1:0] count, int items);
    int                 pick, n;
    logic [VertexW-1:0] row_idx, root;
    write_vertex_count(count);
    sender_idle_pct = idle_pct;
    n = active_vertices();
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) drain_visits();
      pick = $urandom_range(99);
      row_idx = VertexW'($urandom_range(1, MaxVertices));
      if ($urandom_range(9) == 0)
        row_idx = ($urandom_range(1) != 0) ? VertexW'(0) :
                  VertexW'($urandom_range(MaxVertices + 1, 63));
      root = (n > 0) ? VertexW'($urandom_range(1, n)) : VertexW'(1);
      if (pick < 30)
        send_item(ModeLoad, row_idx, random_row(), VertexW'($urandom));
      else if (pick < 62)
        send_item(ModeBfs, VertexW'($urandom), $urandom, root);
      else if (pick < 94)
        send_item(ModeDfs, VertexW'($urandom), $urandom, root);
      else if (pick < 97)
        send_item(ModeUnused, VertexW'($urandom), $urandom, VertexW'($urandom));
      else begin
        root = ($urandom_range(1) != 0) ? VertexW'(0) : VertexW'($urandom_range(n + 1, 63));
        send_item(($urandom_range(1) != 0) ? ModeBfs : ModeDfs, VertexW'($urandom), $urandom,
                  root);
      end
    end
  endtask

  // Check each strobed vertex against the oldest owed visit.
  always @(posedge clk_i) begin
    visit_t want;
    if (rst_ni && vertex_valid_o) begin
      if (visit_q.size() == 0) begin
        $display("%0t: vertex %0d (last %0b) emitted with nothing expected",
                 $time, vertex_o, last_o);
        error_count++;
      end else begin
        want = visit_q.pop_front();
        if (vertex_o !== want.vertex) begin
          $display("%0t: vertex mismatch: expected %0d, got %0d", $time, want.vertex, vertex_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last flag mismatch on vertex %0d: expected %0b, got %0b",
                   $time, want.vertex, want.last, last_o);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d visits still owed", $time, visit_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // Hold reset at the start, then release it once for the whole run.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_matrix_load();
    test_complete_graph();
    test_isolated_vertex();
    test_ignored_items();
    test_vertex_count();

    // No idling, sender idling often, a steady phase, then sender idling sometimes.
    test_random_traffic(0, CountW'(32), 28);
    test_random_traffic(65, CountW'(9), 28);
    test_random_traffic(0, CountW'(20), 28);
    test_random_traffic(28, CountW'(32), 28);

    drain_visits();
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gtr_pkg.sv
rtl/gtr_scan_lane.sv
rtl/gtr_scan_merge.sv
rtl/graph_traversal_bfs_dfs_top.sv
rtl/gtr_checker.sv
tb/sv/graph_traversal_bfs_dfs_top_tb.sv
